/* hw/rtl/pcsrz_pkg.sv */
// Package: shared types and constants for the point cloud stride/ROI/Z filter
`default_nettype none
package pcsrz_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ROI_ROW_FIRST = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROI_ROW_END   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_COL_STEP      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ROW_STEP      = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SCAN_STEP     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_Z_MIN         = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_Z_MAX         = 3'd7;

  localparam logic [12:0] ROW_LIMIT = 13'd8191;

  typedef struct packed {
    logic        from_scan;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic        end_of_cloud;
  } point_in_t;

  typedef struct packed {
    logic        kept_from_scan;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
  } point_out_t;

  // IEEE single a <= b, with signed zeros equal; neither may be NaN
  function automatic logic fp_le(input logic [31:0] a, input logic [31:0] b);
    logic both_zero;
    begin
      both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
      if (both_zero) begin
        fp_le = 1'b1;
      end else if (a[31] != b[31]) begin
        fp_le = a[31];
      end else if (a[31] == 1'b0) begin
        fp_le = (a[30:0] <= b[30:0]);
      end else begin
        fp_le = (a[30:0] >= b[30:0]);
      end
    end
  endfunction

  function automatic logic fp_nan(input logic [31:0] a);
    fp_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/pcsrz_front.sv */
// Front part: counters, stride phases and keep decision for each accepted word
`default_nettype none
module pcsrz_front #(
  parameter int unsigned MaxWidth  = 4096,
  parameter int unsigned MaxStride = 255
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 take_i,
  input  wire pcsrz_pkg::point_in_t pt_i,
  input  wire logic [12:0]          frame_width_i,
  input  wire logic [12:0]          roi_row_first_i,
  input  wire logic [12:0]          roi_row_end_i,
  input  wire logic [7:0]           col_step_i,
  input  wire logic [7:0]           row_step_i,
  input  wire logic [7:0]           scan_step_i,
  input  wire logic [31:0]          z_min_i,
  input  wire logic [31:0]          z_max_i,
  output logic                      keep_o
);

  localparam int unsigned PhW = (MaxStride > 1) ? $clog2(MaxStride) : 1;
  localparam int unsigned FwW = $clog2(MaxWidth + 1);
  localparam int unsigned CiW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned CmpW = (FwW > 13) ? FwW : 13;
  localparam int unsigned SW = (PhW > 8) ? PhW + 1 : 9;

  logic [CiW-1:0] col_index_q, col_index_d;
  logic [12:0]    row_index_q, row_index_d;
  logic [PhW-1:0] col_phase_q, col_phase_d;
  logic [PhW-1:0] row_phase_q, row_phase_d;
  logic [PhW-1:0] scan_phase_q, scan_phase_d;

  // Clamp a stride register to [1, MaxStride]
  function automatic logic [SW-1:0] eff_stride(input logic [7:0] s);
    logic [SW-1:0] v;
    begin
      v = SW'(s);
      if (v == '0) v = SW'(1);
      if (v > SW'(MaxStride)) v = SW'(MaxStride);
      eff_stride = v;
    end
  endfunction

  function automatic logic [PhW-1:0] next_phase(input logic [PhW-1:0] ph,
                                                input logic [SW-1:0] st);
    logic [SW-1:0] n;
    begin
      n = SW'(ph) + SW'(1);
      next_phase = (n >= st) ? '0 : PhW'(n);
    end
  endfunction

  logic [CmpW-1:0] fw_c;
  logic            zok, in_rows, wrap;
  logic [SW-1:0]   us, vs, ss;

  always_comb begin
    fw_c = CmpW'(frame_width_i);
    if (fw_c > CmpW'(MaxWidth)) fw_c = CmpW'(MaxWidth);
    us = eff_stride(col_step_i);
    vs = eff_stride(row_step_i);
    ss = eff_stride(scan_step_i);
    zok = (pt_i.pz[30:23] != 8'hFF)
        && (pcsrz_pkg::fp_nan(z_min_i) || pcsrz_pkg::fp_le(z_min_i, pt_i.pz))
        && (pcsrz_pkg::fp_nan(z_max_i) || pcsrz_pkg::fp_le(pt_i.pz, z_max_i));
    in_rows = (row_index_q >= roi_row_first_i) && (row_index_q < roi_row_end_i);
    wrap = (CmpW'(col_index_q) + CmpW'(1)) >= fw_c;
  end

  // Decide and advance counters
  always_comb begin
    col_index_d  = col_index_q;
    row_index_d  = row_index_q;
    col_phase_d  = col_phase_q;
    row_phase_d  = row_phase_q;
    scan_phase_d = scan_phase_q;
    keep_o       = 1'b0;
    if (pt_i.from_scan) begin
      keep_o = zok && (scan_phase_q == '0);
      scan_phase_d = next_phase(scan_phase_q, ss);
      if (pt_i.end_of_cloud) scan_phase_d = '0;
    end else begin
      if (fw_c == '0) begin
        keep_o = zok && (col_phase_q == '0);
        col_phase_d = next_phase(col_phase_q, us);
      end else begin
        keep_o = zok && in_rows && (col_phase_q == '0) && (row_phase_q == '0);
        if (wrap) begin
          col_index_d = '0;
          col_phase_d = '0;
          if (row_index_q < pcsrz_pkg::ROW_LIMIT) begin
            row_index_d = row_index_q + 13'd1;
            row_phase_d = next_phase(row_phase_q, vs);
          end
        end else begin
          col_index_d = col_index_q + CiW'(1);
          col_phase_d = next_phase(col_phase_q, us);
        end
      end
      if (pt_i.end_of_cloud) begin
        col_index_d = '0;
        row_index_d = '0;
        col_phase_d = '0;
        row_phase_d = '0;
      end
    end
  end

  // Hold state unless a word is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_index_q  <= '0;
      row_index_q  <= '0;
      col_phase_q  <= '0;
      row_phase_q  <= '0;
      scan_phase_q <= '0;
    end else if (take_i) begin
      col_index_q  <= col_index_d;
      row_index_q  <= row_index_d;
      col_phase_q  <= col_phase_d;
      row_phase_q  <= row_phase_d;
      scan_phase_q <= scan_phase_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/pcsrz_queue.sv */
// Back part: short result queue between the decision logic and the output
`default_nettype none
module pcsrz_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  wr_i,
  input  wire pcsrz_pkg::point_out_t wdata_i,
  input  wire logic                  pop_i,
  output logic                       full_o,
  output logic                       empty_o,
  output pcsrz_pkg::point_out_t      rdata_o
);

  pcsrz_pkg::point_out_t mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rptr_q];
  assign do_pop  = pop_i && !empty_o;

  // Store incoming words
  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= wdata_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (wr_i) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/point_cloud_stride_roi_z_filter.sv */
// Top level: point cloud passthrough and decimation filter
//
//  port group   direction  handshake          payload
//  cfg          in         cfg_we_i           cfg_idx_i, cfg_data_i
//  points in    in         push / full        pt_i (point_in_t)
//  points out   out        pop / empty        res_o (point_out_t)
//
// One word per cycle while the queue is not full: the decision is combinational on
// the accepted word and a kept word is written into a two-entry queue at that same edge.
// A kept word is registered in the queue and shows on res_o once every word ahead of it is popped.
// full rises only when both queue entries hold unread results.
// Reset clears all counters, restores register defaults and empties the queue.
`default_nettype none
module point_cloud_stride_roi_z_filter #(
  parameter int unsigned MaxWidth  = 4096,
  parameter int unsigned MaxStride = 255
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [pcsrz_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [pcsrz_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic                               push,
  output logic                                    full,
  input  wire pcsrz_pkg::point_in_t               pt_i,
  output logic                                    empty,
  input  wire logic                               pop,
  output pcsrz_pkg::point_out_t                   res_o
);

  logic [12:0] frame_width_q, roi_row_first_q, roi_row_end_q;
  logic [7:0]  col_step_q, row_step_q, scan_step_q;
  logic [31:0] z_min_q, z_max_q;
  logic        take, keep;
  pcsrz_pkg::point_out_t wdata;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q   <= 13'd0;
      roi_row_first_q <= 13'd0;
      roi_row_end_q   <= 13'd4096;
      col_step_q      <= 8'd2;
      row_step_q      <= 8'd2;
      scan_step_q     <= 8'd1;
      z_min_q         <= 32'hBF80_0000;
      z_max_q         <= 32'h3F80_0000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcsrz_pkg::REG_FRAME_WIDTH:   frame_width_q   <= cfg_data_i[12:0];
        pcsrz_pkg::REG_ROI_ROW_FIRST: roi_row_first_q <= cfg_data_i[12:0];
        pcsrz_pkg::REG_ROI_ROW_END:   roi_row_end_q   <= cfg_data_i[12:0];
        pcsrz_pkg::REG_COL_STEP:      col_step_q      <= cfg_data_i[7:0];
        pcsrz_pkg::REG_ROW_STEP:      row_step_q      <= cfg_data_i[7:0];
        pcsrz_pkg::REG_SCAN_STEP:     scan_step_q     <= cfg_data_i[7:0];
        pcsrz_pkg::REG_Z_MIN:         z_min_q         <= cfg_data_i;
        pcsrz_pkg::REG_Z_MAX:         z_max_q         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign take = push && !full;

  pcsrz_front #(.MaxWidth(MaxWidth), .MaxStride(MaxStride)) u_front (
    .clk_i, .rst_ni, .take_i(take), .pt_i,
    .frame_width_i(frame_width_q), .roi_row_first_i(roi_row_first_q),
    .roi_row_end_i(roi_row_end_q), .col_step_i(col_step_q),
    .row_step_i(row_step_q), .scan_step_i(scan_step_q),
    .z_min_i(z_min_q), .z_max_i(z_max_q), .keep_o(keep)
  );

  // Pass the point through unchanged
  always_comb begin
    wdata.kept_from_scan = pt_i.from_scan;
    wdata.out_x = pt_i.px;
    wdata.out_y = pt_i.py;
    wdata.out_z = pt_i.pz;
  end

  pcsrz_queue u_queue (
    .clk_i, .rst_ni, .wr_i(take && keep), .wdata_i(wdata), .pop_i(pop),
    .full_o(full), .empty_o(empty), .rdata_o(res_o)
  );

  // A taken word that is kept leaves the queue non-empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && keep) |=> !empty) else $error("kept word lost");
  // A non-finite Z never enters the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && pt_i.pz[30:23] == 8'hFF) |-> !keep) else $error("non-finite Z kept");
  // Queue cannot be both full and empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(full && empty)) else $error("queue state broken");

endmodule
`default_nettype wire

/* tb/pcsrz_checker.sv */
// Checker: predicts kept points from accepted input words and compares each popped word
module pcsrz_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pcsrz_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [pcsrz_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                           push_i,
  input  wire logic                           full_i,
  input  wire pcsrz_pkg::point_in_t           pt_i,
  input  wire logic                           empty_i,
  input  wire logic                           pop_i,
  input  wire pcsrz_pkg::point_out_t          res_i,
  output int                                  err_count_o,
  output int                                  pending_o,
  output int                                  checked_o
);

  localparam int unsigned WidthCap  = 4096;
  localparam int unsigned StrideCap = 255;
  localparam int          ExpDepth  = 64;

  // register copy
  logic [12:0] frame_width, row_first, row_end;
  logic [7:0]  col_step, row_step, scan_step;
  logic [31:0] z_lo, z_hi;

  // counter copy
  logic [11:0] col_idx;
  logic [12:0] row_idx;
  logic [7:0]  col_ph, row_ph, scan_ph;

  // expected words, oldest first
  pcsrz_pkg::point_out_t exp_mem [ExpDepth];
  int exp_wr;
  int exp_rd;
  int errs;
  int n_checked;

  assign err_count_o = errs;
  assign pending_o   = exp_wr - exp_rd;
  assign checked_o   = n_checked;

  function automatic logic [8:0] eff_step(input logic [7:0] s);
    logic [8:0] v;
    v = (s == 8'd0) ? 9'd1 : {1'b0, s};
    if (v > 9'(StrideCap)) v = 9'(StrideCap);
    return v;
  endfunction

  function automatic logic [7:0] step_phase(input logic [7:0] ph, input logic [8:0] st);
    return ({1'b0, ph} + 9'd1 >= st) ? 8'd0 : ph + 8'd1;
  endfunction

  // map a single to an unsigned key that orders like the float, zeros merged
  function automatic logic [31:0] order_key(input logic [31:0] b);
    if (b[30:0] == 31'd0) return 32'h8000_0000;
    if (b[31]) return ~b;
    return b | 32'h8000_0000;
  endfunction

  function automatic logic is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic logic z_ok(input logic [31:0] z);
    if (z[30:23] == 8'hFF) return 1'b0;
    if (!is_nan(z_lo) && order_key(z) < order_key(z_lo)) return 1'b0;
    if (!is_nan(z_hi) && order_key(z) > order_key(z_hi)) return 1'b0;
    return 1'b1;
  endfunction

  // predict one accepted word and advance the counters
  task automatic predict_point(input pcsrz_pkg::point_in_t p);
    logic                  keep;
    logic                  zk;
    logic [12:0]           fw;
    logic                  in_rows;
    pcsrz_pkg::point_out_t o;
    begin
      zk = z_ok(p.pz);
      if (p.from_scan) begin
        keep = zk && (scan_ph == 8'd0);
        scan_ph = step_phase(scan_ph, eff_step(scan_step));
        if (p.end_of_cloud) scan_ph = 8'd0;
      end else begin
        fw = (frame_width > WidthCap) ? 13'(WidthCap) : frame_width;
        if (fw == 13'd0) begin
          keep = zk && (col_ph == 8'd0);
          col_ph = step_phase(col_ph, eff_step(col_step));
        end else begin
          in_rows = (row_idx >= row_first) && (row_idx < row_end);
          keep = zk && in_rows && (col_ph == 8'd0) && (row_ph == 8'd0);
          if ({1'b0, col_idx} + 13'd1 >= fw) begin
            col_idx = 12'd0;
            col_ph = 8'd0;
            if (row_idx < pcsrz_pkg::ROW_LIMIT) begin
              row_idx = row_idx + 13'd1;
              row_ph = step_phase(row_ph, eff_step(row_step));
            end
          end else begin
            col_idx = col_idx + 12'd1;
            col_ph = step_phase(col_ph, eff_step(col_step));
          end
        end
        if (p.end_of_cloud) begin
          col_idx = '0;
          row_idx = '0;
          col_ph = '0;
          row_ph = '0;
        end
      end
      if (keep) begin
        o.kept_from_scan = p.from_scan;
        o.out_x = p.px;
        o.out_y = p.py;
        o.out_z = p.pz;
        if (exp_wr - exp_rd >= ExpDepth) begin
          errs++;
          if (errs <= 10) $display("expected words overflow, dropped: %h", o);
        end else begin
          exp_mem[exp_wr % ExpDepth] = o;
          exp_wr++;
        end
      end
    end
  endtask

  // compare one popped word against the oldest prediction
  task automatic check_word(input pcsrz_pkg::point_out_t got);
    pcsrz_pkg::point_out_t want;
    begin
      if (exp_wr == exp_rd) begin
        errs++;
        if (errs <= 10) $display("unexpected word: %h", got);
      end else begin
        want = exp_mem[exp_rd % ExpDepth];
        exp_rd++;
        n_checked++;
        if (want.kept_from_scan != got.kept_from_scan || want.out_x != got.out_x ||
            want.out_y != got.out_y || want.out_z != got.out_z) begin
          errs++;
          if (errs <= 10)
            $display("mismatch: want src=%b x=%h y=%h z=%h got src=%b x=%h y=%h z=%h",
                     want.kept_from_scan, want.out_x, want.out_y, want.out_z,
                     got.kept_from_scan, got.out_x, got.out_y, got.out_z);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width = 13'd0;
      row_first = 13'd0;
      row_end = 13'd4096;
      col_step = 8'd2;
      row_step = 8'd2;
      scan_step = 8'd1;
      z_lo = 32'hBF80_0000;
      z_hi = 32'h3F80_0000;
      col_idx = '0;
      row_idx = '0;
      col_ph = '0;
      row_ph = '0;
      scan_ph = '0;
      exp_wr = 0;
      exp_rd = 0;
      errs = 0;
      n_checked = 0;
    end else begin
      if (pop_i && !empty_i) check_word(res_i);
      // a word taken at this edge still sees the old register values
      if (push_i && !full_i) predict_point(pt_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pcsrz_pkg::REG_FRAME_WIDTH:   frame_width = cfg_data_i[12:0];
          pcsrz_pkg::REG_ROI_ROW_FIRST: row_first = cfg_data_i[12:0];
          pcsrz_pkg::REG_ROI_ROW_END:   row_end = cfg_data_i[12:0];
          pcsrz_pkg::REG_COL_STEP:      col_step = cfg_data_i[7:0];
          pcsrz_pkg::REG_ROW_STEP:      row_step = cfg_data_i[7:0];
          pcsrz_pkg::REG_SCAN_STEP:     scan_step = cfg_data_i[7:0];
          pcsrz_pkg::REG_Z_MIN:         z_lo = cfg_data_i;
          pcsrz_pkg::REG_Z_MAX:         z_hi = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

/* tb/tb_point_cloud_stride_roi_z_filter.sv */
// Testbench top: drives points and register writes into the filter and gives the verdict
module tb_point_cloud_stride_roi_z_filter;

  localparam int CycleLimit = 2_000_000;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [pcsrz_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [pcsrz_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                           push = 1'b0;
  logic                           full;
  pcsrz_pkg::point_in_t           pt_i = '0;
  logic                           empty;
  logic                           pop = 1'b0;
  pcsrz_pkg::point_out_t          res_o;

  int err_count, pending, checked;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_tokens = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int cycles = 0;
  int n_sent = 0;
  logic [12:0] cur_width;

  point_cloud_stride_roi_z_filter u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .push(push), .full(full), .pt_i(pt_i),
    .empty(empty), .pop(pop), .res_o(res_o)
  );

  pcsrz_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .push_i(push), .full_i(full), .pt_i(pt_i),
    .empty_i(empty), .pop_i(pop), .res_i(res_o),
    .err_count_o(err_count), .pending_o(pending), .checked_o(checked)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // abort on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_point_cloud_stride_roi_z_filter: errors");
      $finish;
    end
  end

  // pop side: random idling, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken < hold_tokens) begin
      pop <= 1'b0;
      hold_taken <= hold_taken + 1;
      hold_left <= 400;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // random Z: in range, on the bounds, zeros, infinities, NaN or raw bits
  function automatic logic [31:0] rand_z();
    case ($urandom_range(9))
      0: return 32'h3F80_0000;
      1: return 32'hBF80_0000;
      2: return {1'($urandom_range(1)), 31'd0};
      3: return {1'($urandom_range(1)), 8'hFF, 23'd0};
      4: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
      5: return $urandom();
      6: return {1'b0, 8'h7F, 23'($urandom_range(0, 3))};
      default: return {1'($urandom_range(1)), 8'($urandom_range(100, 127)), 23'($urandom())};
    endcase
  endfunction

  function automatic logic [31:0] rand_bound();
    case ($urandom_range(7))
      0: return 32'hBF80_0000;
      1: return 32'h3F80_0000;
      2: return {1'($urandom_range(1)), 31'd0};
      3: return {1'($urandom_range(1)), 8'hFF, 23'd0};
      4: return 32'h7FC0_0000;
      5: return $urandom();
      default: return {1'($urandom_range(1)), 8'($urandom_range(110, 128)), 23'($urandom())};
    endcase
  endfunction

  function automatic logic [7:0] rand_stride();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd255;
      3: return 8'($urandom());
      default: return 8'($urandom_range(2, 4));
    endcase
  endfunction

  // offer one word; called at a rising edge, returns at the accepting edge
  task automatic send_word(input pcsrz_pkg::point_in_t p);
    int gap;
    begin
      if ($urandom_range(99) < send_idle) begin
        push <= 1'b0;
        gap = $urandom_range(1, 4);
        repeat (gap) @(posedge clk_i);
      end
      push <= 1'b1;
      pt_i <= p;
      do @(posedge clk_i); while (full);
      n_sent++;
    end
  endtask

  task automatic send_rand(input logic scan, input logic last);
    pcsrz_pkg::point_in_t p;
    begin
      p.from_scan = scan;
      p.px = $urandom();
      p.py = $urandom();
      p.pz = rand_z();
      p.end_of_cloud = last;
      send_word(p);
    end
  endtask

  // one cloud of n words from one source, closed by end_of_cloud when with_end is set
  task automatic send_cloud(input logic scan, input int n, input logic with_end);
    begin
      for (int i = 0; i < n; i++) send_rand(scan, with_end && (i == n - 1));
    end
  endtask

  // drop push, wait for the queue to drain, then settle
  task automatic drain();
    begin
      push <= 1'b0;
      @(posedge clk_i);
      while (pending != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
    end
  endtask

  // hold the write strobe high; cfg_all drops it after the last register
  task automatic cfg_write(input logic [pcsrz_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
    begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_data_i <= data;
      @(posedge clk_i);
    end
  endtask

  task automatic cfg_all(input logic [12:0] fw, input logic [12:0] rf, input logic [12:0] re,
                         input logic [7:0] su, input logic [7:0] sv, input logic [7:0] ss,
                         input logic [31:0] zl, input logic [31:0] zh);
    begin
      cfg_write(pcsrz_pkg::REG_FRAME_WIDTH, 32'(fw));
      cfg_write(pcsrz_pkg::REG_ROI_ROW_FIRST, 32'(rf));
      cfg_write(pcsrz_pkg::REG_ROI_ROW_END, 32'(re));
      cfg_write(pcsrz_pkg::REG_COL_STEP, 32'(su));
      cfg_write(pcsrz_pkg::REG_ROW_STEP, 32'(sv));
      cfg_write(pcsrz_pkg::REG_SCAN_STEP, 32'(ss));
      cfg_write(pcsrz_pkg::REG_Z_MIN, zl);
      cfg_write(pcsrz_pkg::REG_Z_MAX, zh);
      cfg_we_i <= 1'b0;
      cur_width = fw;
    end
  endtask

  initial begin
    pcsrz_pkg::point_in_t p;
    logic [12:0] fw, rf, re;
    int rows, n, target;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, Z extremes on both sources
    send_idle = 0;
    recv_idle = 0;
    p = '0;
    for (int k = 0; k < 12; k++) begin
      p.from_scan = k[0];
      p.px = (k < 6) ? 32'hFFFF_FFFF : 32'h0;
      p.py = (k < 6) ? 32'h0 : 32'hFFFF_FFFF;
      case (k)
        0: p.pz = 32'hBF80_0000;
        1: p.pz = 32'h3F80_0000;
        2: p.pz = 32'h8000_0000;
        3: p.pz = 32'h0000_0000;
        4: p.pz = 32'h7F80_0000;
        5: p.pz = 32'hFF80_0000;
        6: p.pz = 32'h7FC0_0000;
        7: p.pz = 32'h3F80_0001;
        8: p.pz = 32'hBF80_0001;
        9: p.pz = 32'h0000_0001;
        default: p.pz = 32'hFFFF_FFFF;
      endcase
      p.end_of_cloud = (k == 11);
      send_word(p);
    end
    drain();

    // directed: NaN bounds, signed zero bounds, oversized width, empty window
    cfg_all(13'd8191, 13'd0, 13'd8191, 8'd1, 8'd1, 8'd0, 32'h7FC0_0000, 32'hFFC0_0000);
    send_cloud(1'b0, 4, 1'b1);
    send_cloud(1'b1, 3, 1'b1);
    drain();
    cfg_all(13'd2, 13'd3, 13'd1, 8'd255, 8'd255, 8'd255, 32'h0000_0000, 32'h8000_0000);
    send_cloud(1'b0, 6, 1'b1);
    send_cloud(1'b1, 3, 1'b0);
    drain();

    // random phases of well-formed clouds with some noise words
    for (int ph = 0; ph < 13; ph++) begin
      if (ph < 4) begin
        send_idle = 29; recv_idle = 59;
      end else if (ph < 8) begin
        send_idle = 59; recv_idle = 29;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      case ($urandom_range(4))
        0: fw = 13'd0;
        1: fw = 13'd4096;
        2: fw = 13'($urandom());
        default: fw = 13'($urandom_range(1, 9));
      endcase
      rf = ($urandom_range(3) == 0) ? 13'($urandom()) : 13'($urandom_range(0, 3));
      re = ($urandom_range(3) == 0) ? 13'($urandom()) : 13'($urandom_range(0, 10));
      if (ph == 1) begin
        rf = 13'd0; re = 13'd8191;
      end
      cfg_all(fw, rf, re, rand_stride(), rand_stride(), rand_stride(),
              rand_bound(), rand_bound());
      if (ph == 2) hold_tokens++;
      target = n_sent + 100;
      while (n_sent < target) begin
        case ($urandom_range(9))
          0, 1, 2: send_cloud(1'b1, $urandom_range(1, 12), $urandom_range(3) != 0);
          3: send_rand(1'($urandom_range(1)), 1'($urandom_range(1)));
          default: begin
            if (cur_width != 0 && cur_width <= 9) begin
              rows = $urandom_range(1, 6);
              n = int'(cur_width) * rows;
            end else begin
              n = $urandom_range(3, 20);
            end
            send_cloud(1'b0, n, $urandom_range(4) != 0);
          end
        endcase
      end
      drain();
    end

    // narrow row window on a one-column grid
    send_idle = 0;
    recv_idle = 0;
    cfg_all(13'd1, 13'd5, 13'd20, 8'd1, 8'd1, 8'd1, 32'hFF80_0000, 32'h7F80_0000);
    for (int i = 0; i < 30; i++) begin
      p.from_scan = 1'b0;
      p.px = $urandom();
      p.py = $urandom();
      p.pz = 32'h3F00_0000;
      p.end_of_cloud = (i == 29);
      send_word(p);
    end
    drain();

    repeat (8) @(posedge clk_i);
    $display("sent %0d points, checked %0d kept points across 17 register settings",
             n_sent, checked);
    $display("covered Z extremes, NaN bounds, strides 0/1/255, empty and narrow row windows");
    if (err_count == 0 && pending == 0) begin
      $display("tb_point_cloud_stride_roi_z_filter: clean");
    end else begin
      $display("tb_point_cloud_stride_roi_z_filter: errors");
    end
    $finish;
  end

endmodule
